@@ rtl/core/rspd_pkg.sv @@
// ----------------------------------------------------------------------------
// rspd_pkg
// Types, character codes and helpers shared by the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rspd_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'

  localparam int unsigned MAXP_BITS = 13;
  localparam int unsigned LEN_BITS  = 13;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_CK1  = 2'd2,
    PH_CK2  = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           payload_byte;
    logic [LEN_BITS-1:0]  packet_length;
    logic [7:0]           got_checksum;
    logic [7:0]           sum_checksum;
  } result_t;

  // Digit value in [3:0]; bit 4 set when c is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = 5'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = 5'(c - 8'h41 + 8'd10);
      end
      return v;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rspd_parser.sv @@
// ----------------------------------------------------------------------------
// rspd_parser
// Frame state machine: hunts for the start marker, forwards payload bytes
// with a running sum, reads the two checksum characters and builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module rspd_parser #(
  parameter int unsigned COUNT_BITS = 13
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              fire,
  input  wire  [7:0]                       rx_byte,
  input  wire  [rspd_pkg::MAXP_BITS-1:0]   max_payload,
  output logic                             res_load,
  output rspd_pkg::result_t                res
);

  localparam int unsigned LW =
    (COUNT_BITS > rspd_pkg::MAXP_BITS) ? COUNT_BITS : rspd_pkg::MAXP_BITS;

  rspd_pkg::phase_t        phase, phase_next;
  logic [7:0]              running_sum, running_sum_next;
  logic [COUNT_BITS-1:0]   byte_count, byte_count_next;
  logic [7:0]              first_hex_char, first_hex_char_next;

  logic [LW-1:0]           cnt_max_ext;
  logic [LW-1:0]           maxp_ext;
  logic [LW-1:0]           limit;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [LW-1:0]           count_inc_ext;
  logic [LW-1:0]           count_ext;
  logic [4:0]              h1, h2;
  logic [7:0]              got;

  always_comb begin
    cnt_max_ext   = LW'({COUNT_BITS{1'b1}});
    maxp_ext      = LW'(max_payload);
    limit         = (maxp_ext < cnt_max_ext) ? maxp_ext : cnt_max_ext;
    count_inc     = byte_count + COUNT_BITS'(1);
    count_inc_ext = LW'(count_inc);
    count_ext     = LW'(byte_count);
    h1            = rspd_pkg::hex_val(first_hex_char);
    h2            = rspd_pkg::hex_val(rx_byte);
    if (h1[4]) begin
      got = 8'h00;
    end else if (h2[4]) begin
      got = {4'h0, h1[3:0]};
    end else begin
      got = {h1[3:0], h2[3:0]};
    end
  end

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    byte_count_next     = byte_count;
    first_hex_char_next = first_hex_char;
    res_load            = 1'b0;
    res                 = '0;
    res.kind            = rspd_pkg::KIND_DATA;
    if (fire) begin
      case (phase)
        rspd_pkg::PH_HUNT: begin
          if (rx_byte == rspd_pkg::CH_START) begin
            running_sum_next = 8'h00;
            byte_count_next  = '0;
            phase_next = (limit == '0) ? rspd_pkg::PH_CK1 : rspd_pkg::PH_DATA;
          end
        end
        rspd_pkg::PH_DATA: begin
          if (rx_byte == rspd_pkg::CH_END) begin
            phase_next = rspd_pkg::PH_CK1;
          end else begin
            running_sum_next = running_sum + rx_byte;
            byte_count_next  = count_inc;
            // limit is checked after the byte is stored
            if (count_inc_ext >= limit) begin
              phase_next = rspd_pkg::PH_CK1;
            end
            res_load         = 1'b1;
            res.payload_byte = rx_byte;
          end
        end
        rspd_pkg::PH_CK1: begin
          first_hex_char_next = rx_byte;
          phase_next          = rspd_pkg::PH_CK2;
        end
        rspd_pkg::PH_CK2: begin
          res_load          = 1'b1;
          res.kind          = (got == running_sum) ? rspd_pkg::KIND_ACK
                                                   : rspd_pkg::KIND_NAK;
          res.packet_length = count_ext[rspd_pkg::LEN_BITS-1:0];
          res.got_checksum  = got;
          res.sum_checksum  = running_sum;
          phase_next          = rspd_pkg::PH_HUNT;
          running_sum_next    = 8'h00;
          byte_count_next     = '0;
          first_hex_char_next = 8'h00;
        end
        default: begin
          phase_next = rspd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rspd_pkg::PH_HUNT;
      running_sum    <= 8'h00;
      byte_count     <= '0;
      first_hex_char <= 8'h00;
    end else begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      byte_count     <= byte_count_next;
      first_hex_char <= first_hex_char_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rsp_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_deframer_core
// Receive-side deframer for remote serial protocol packets.
// ----------------------------------------------------------------------------
// Takes one link byte per request and sustains one byte per cycle while the
// consumer takes results. A byte is registered at the input. Once the output
// register is free, the frame logic updates its state and loads at most one
// result into the output register. A result is therefore presented in the
// cycle after the edge that accepts the byte behind the input register. rx_stall
// rises only while a byte waits in the input register and the output register
// holds a result that the consumer is stalling. Results: kind DATA for every
// payload byte, then ACK or NAK with length and both checksums at packet end.
`default_nettype none

module rsp_packet_deframer_core #(
  parameter int unsigned COUNT_BITS = 13
) (
  input  wire         clk,
  input  wire         rst,
  // received bytes
  input  wire         rx_valid,
  output logic        rx_stall,
  input  wire  [7:0]  rx_byte,
  // results
  output logic        res_valid,
  input  wire         res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [12:0] packet_length,
  output logic [7:0]  got_checksum,
  output logic [7:0]  sum_checksum,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                               s1_valid;
  logic [7:0]                         s1_byte;
  logic                               s1_fire;
  logic                               out_free;
  logic [rspd_pkg::MAXP_BITS-1:0]     max_payload;
  logic                               res_load;
  rspd_pkg::result_t                  res_comb;
  rspd_pkg::result_t                  res_q;

  assign pready   = 1'b1;
  assign out_free = !res_valid || !res_stall;
  assign s1_fire  = s1_valid && out_free;
  assign rx_stall = s1_valid && !out_free;

  // config register, word 0
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= rspd_pkg::MAXP_BITS'(255);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_payload <= pwdata[rspd_pkg::MAXP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = 32'(max_payload);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      s1_byte <= rx_byte;
    end
  end

  rspd_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .rx_byte     (s1_byte),
    .max_payload (max_payload),
    .res_load    (res_load),
    .res         (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_load) begin
      res_q <= res_comb;
    end
  end

  assign kind          = res_q.kind;
  assign payload_byte  = res_q.payload_byte;
  assign packet_length = res_q.packet_length;
  assign got_checksum  = res_q.got_checksum;
  assign sum_checksum  = res_q.sum_checksum;

endmodule

`default_nettype wire

@@ rtl/core/rspd_checker.sv @@
// ----------------------------------------------------------------------------
// rspd_port_checks
// Port-level checks for the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rspd_port_checks (
  input wire        clk,
  input wire        rst,
  input wire        res_valid,
  input wire        res_stall,
  input wire [1:0]  kind,
  input wire [12:0] packet_length,
  input wire [7:0]  got_checksum,
  input wire [7:0]  sum_checksum
);

  // a stalled result stays presented
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind))
    else $error("result dropped while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> kind == rspd_pkg::KIND_DATA || kind == rspd_pkg::KIND_ACK ||
                  kind == rspd_pkg::KIND_NAK)
    else $error("undefined result kind");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == rspd_pkg::KIND_DATA |->
      packet_length == 13'd0 && got_checksum == 8'd0 && sum_checksum == 8'd0)
    else $error("packet-end fields set on a payload byte");

  a_ack_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != rspd_pkg::KIND_DATA |->
      (kind == rspd_pkg::KIND_ACK) == (got_checksum == sum_checksum))
    else $error("ack/nak disagrees with checksums");

endmodule

bind rsp_packet_deframer_core rspd_port_checks u_rspd_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .kind          (kind),
  .packet_length (packet_length),
  .got_checksum  (got_checksum),
  .sum_checksum  (sum_checksum)
);

`default_nettype wire
